/* sv/et_pkg.sv */
package et_pkg;

	// Longest text the block is sized for; positions and lengths saturate below it.
	localparam int unsigned MAX_TEXT_LEN = 65536;
	localparam int unsigned PosCapInt = ((MAX_TEXT_LEN - 1) > 65535) ? 65535
		: (MAX_TEXT_LEN - 1);
	localparam logic [15:0] POS_CAP = 16'(PosCapInt);

	// At most three tokens come out of one byte.
	localparam int unsigned MAX_RESULTS = 3;
	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);

	typedef enum logic [3:0] {
		KIND_NUMBER    = 4'd0,
		KIND_IMAGINARY = 4'd1,
		KIND_VARIABLE  = 4'd2,
		KIND_OPERATOR  = 4'd3,
		KIND_LPAREN    = 4'd4,
		KIND_RPAREN    = 4'd5,
		KIND_LBRACKET  = 4'd6,
		KIND_RBRACKET  = 4'd7,
		KIND_COMMA     = 4'd8,
		KIND_SEMICOLON = 4'd9,
		KIND_END       = 4'd10
	} kind_t;

	typedef enum logic [4:0] {
		MODE_IDLE  = 5'b00001,
		MODE_INT   = 5'b00010,
		MODE_DOT   = 5'b00100,
		MODE_FRAC  = 5'b01000,
		MODE_IDENT = 5'b10000
	} mode_t;

	typedef struct packed {
		logic        last;
		logic [15:0] len;
		logic [15:0] start;
		kind_t       kind;
	} tok_t;

	// Tokens produced by one byte, valid from index 0 up to cnt-1.
	typedef struct packed {
		logic [1:0]     cnt;
		tok_t [2:0]     tok;
	} tok_group_t;

	function automatic logic [15:0] sat_add(logic [15:0] a, logic [1:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {15'b0, b};
		return (s > {1'b0, POS_CAP}) ? POS_CAP : s[15:0];
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return c inside {["a":"z"], ["A":"Z"]};
	endfunction

	// Single-byte tokens: returns valid flag and kind.
	function automatic logic [4:0] single_kind(logic [7:0] c);
		logic [4:0] r;
		case (c)
			"+", "-", "*", "/", "%", "=": r = {1'b1, KIND_OPERATOR};
			"(": r = {1'b1, KIND_LPAREN};
			")": r = {1'b1, KIND_RPAREN};
			"[": r = {1'b1, KIND_LBRACKET};
			"]": r = {1'b1, KIND_RBRACKET};
			",": r = {1'b1, KIND_COMMA};
			";": r = {1'b1, KIND_SEMICOLON};
			default: r = {1'b0, KIND_NUMBER};
		endcase
		return r;
	endfunction

	// Token for whatever is pending in a non-idle mode.
	function automatic tok_t pending_tok(mode_t m, logic [15:0] st, logic [15:0] cnt,
			logic starts_i);
		tok_t t;
		t.last  = 1'b0;
		t.start = st;
		t.len   = cnt;
		if (m == MODE_IDENT)
			t.kind = (cnt == 16'd1 && starts_i) ? KIND_IMAGINARY : KIND_VARIABLE;
		else
			t.kind = KIND_NUMBER;
		return t;
	endfunction

endpackage

/* sv/et_scan.sv */
module et_scan import et_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	output tok_group_t res_s1
);

	mode_t       mode_q, mode_d;
	logic [15:0] start_q, start_d;
	logic [15:0] count_q, count_d;
	logic        si_q, si_d;
	logic [15:0] pos_q, pos_d;
	tok_group_t  res_d;

	logic        close_pend;
	logic        do_begin;
	logic [1:0]  n;
	logic [4:0]  sk;

	always_comb begin
		mode_d     = mode_q;
		start_d    = start_q;
		count_d    = count_q;
		si_d       = si_q;
		close_pend = 1'b0;
		do_begin   = 1'b0;
		n          = 2'd0;
		res_d      = '0;
		sk         = single_kind(char_code);

		case (mode_q)
			MODE_INT: begin
				if (is_digit(char_code))
					count_d = sat_add(count_q, 2'd1);
				else if (char_code == ".")
					mode_d = MODE_DOT;
				else begin
					close_pend = 1'b1;
					do_begin   = 1'b1;
				end
			end
			MODE_DOT: begin
				if (is_digit(char_code)) begin
					count_d = sat_add(count_q, 2'd2);
					mode_d  = MODE_FRAC;
				end else begin
					close_pend = 1'b1;
					do_begin   = 1'b1;
				end
			end
			MODE_FRAC: begin
				if (is_digit(char_code))
					count_d = sat_add(count_q, 2'd1);
				else begin
					close_pend = 1'b1;
					do_begin   = 1'b1;
				end
			end
			MODE_IDENT: begin
				if (is_letter(char_code) || is_digit(char_code) || char_code == "_")
					count_d = sat_add(count_q, 2'd1);
				else begin
					close_pend = 1'b1;
					do_begin   = 1'b1;
				end
			end
			default: begin
				mode_d   = MODE_IDLE;
				do_begin = 1'b1;
			end
		endcase

		if (close_pend) begin
			res_d.tok[n] = pending_tok(mode_q, start_q, count_q, si_q);
			n            = n + 2'd1;
			mode_d       = MODE_IDLE;
		end

		if (do_begin) begin
			if (is_digit(char_code)) begin
				mode_d  = MODE_INT;
				start_d = pos_q;
				count_d = 16'd1;
			end else if (is_letter(char_code)) begin
				mode_d  = MODE_IDENT;
				start_d = pos_q;
				count_d = 16'd1;
				si_d    = (char_code == "i");
			end else if (sk[4]) begin
				res_d.tok[n].kind  = kind_t'(sk[3:0]);
				res_d.tok[n].start = pos_q;
				res_d.tok[n].len   = 16'd1;
				n                  = n + 2'd1;
			end
		end

		if (end_of_text) begin
			if (mode_d != MODE_IDLE) begin
				res_d.tok[n] = pending_tok(mode_d, start_d, count_d, si_d);
				n            = n + 2'd1;
			end
			res_d.tok[n].kind  = KIND_END;
			res_d.tok[n].start = sat_add(pos_q, 2'd1);
			res_d.tok[n].len   = 16'd0;
			n                  = n + 2'd1;
			mode_d             = MODE_IDLE;
			pos_d              = 16'd0;
		end else begin
			pos_d = sat_add(pos_q, 2'd1);
		end

		if (n != 2'd0)
			res_d.tok[n - 2'd1].last = 1'b1;
		res_d.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			count_q <= '0;
			si_q    <= 1'b0;
			pos_q   <= '0;
		end else if (take) begin
			mode_q  <= mode_d;
			start_q <= start_d;
			count_q <= count_d;
			si_q    <= si_d;
			pos_q   <= pos_d;
		end
	end

	// Result register; cnt is zero in any cycle with no transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_s1 <= '0;
		else begin
			res_s1.cnt <= take ? res_d.cnt : 2'd0;
			res_s1.tok <= res_d.tok;
		end
	end

endmodule

/* sv/et_token_fifo.sv */
module et_token_fifo import et_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tok_group_t push,
	output logic       room,
	output logic       out_valid,
	input  logic       out_ready,
	output tok_t       out_tok
);

	tok_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW:0]     count_q;
	logic                 pop;
	logic [FIFO_AW+1:0]   fill;

	assign out_valid = (count_q != '0);
	assign out_tok   = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// Room for a full burst on top of what is queued or still in the result register.
	assign fill = {1'b0, count_q} + {{FIFO_AW{1'b0}}, push.cnt};
	assign room = (fill <= (FIFO_AW+2)'(FIFO_DEPTH - MAX_RESULTS));

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (2'(i) < push.cnt)
				mem_q[wr_ptr_q + FIFO_AW'(i)] <= push.tok[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + (FIFO_AW+1)'(push.cnt) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

/* sv/expression_tokenizer.sv */
// Expression tokenizer. Text enters one byte per transfer on s_*, s_tlast marking
// the final byte; tokens leave on m_* as kind, start position and length, with
// m_tlast on the last token caused by a byte. One byte is taken every cycle while
// s_tready is high: the scanner updates its state in the cycle of the transfer and registers up
// to three tokens, which the next cycle writes into an eight-entry token queue. A token
// reaches m_* by way of the result register and the queue. s_tready drops only
// when the queue, counting the tokens still in the result register, cannot take
// another burst of three; as long as m_* drains one token a cycle and bytes give
// one token each on average, the input runs at one byte per cycle. The last byte
// of a text also emits an end token and restarts positions at zero.
module expression_tokenizer import et_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [3:0] token_kind, [19:4] start_pos, [35:20] token_length
	output logic        m_tlast    // last_of_run
);

	tok_group_t res_s1;
	tok_t       head;
	logic       take;

	assign take = s_tvalid && s_tready;

	et_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.char_code   (s_tdata),
		.end_of_text (s_tlast),
		.res_s1      (res_s1)
	);

	et_token_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_s1),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (head)
	);

	assign m_tdata = {4'b0, head.len, head.start, head.kind};
	assign m_tlast = head.last;

endmodule

/* verif/expression_tokenizer_tb.sv */
module expression_tokenizer_tb;
	import et_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_BYTES = 500;
	localparam int CALM_FROM = 420;
	localparam int TAIL_CYCLES = 20;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_INT,
		SC_DOT,
		SC_FRAC,
		SC_IDENT
	} scan_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] len;
		logic        last;
	} token_t;

	// typed rows carry the single token the byte must give
	typedef struct packed {
		logic [7:0]  ch;
		logic        eot;
		logic        typed;
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] len;
	} dir_row_t;

	localparam dir_row_t DIRECTED [0:27] = '{
		'{"(",   1'b0, 1'b1, KIND_LPAREN,    16'd0,  16'd1},
		'{"i",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"+",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"1",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"2",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{".",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"5",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"*",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"7",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{".",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"x",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"_",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"9",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"]",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"[",   1'b0, 1'b1, KIND_LBRACKET,  16'd14, 16'd1},
		'{",",   1'b0, 1'b1, KIND_COMMA,     16'd15, 16'd1},
		'{"-",   1'b0, 1'b1, KIND_OPERATOR,  16'd16, 16'd1},
		'{8'hFF, 1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"_",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{".",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"/",   1'b0, 1'b1, KIND_OPERATOR,  16'd20, 16'd1},
		'{";",   1'b0, 1'b1, KIND_SEMICOLON, 16'd21, 16'd1},
		'{"=",   1'b0, 1'b1, KIND_OPERATOR,  16'd22, 16'd1},
		'{")",   1'b1, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"5",   1'b1, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{"%",   1'b0, 1'b1, KIND_OPERATOR,  16'd0,  16'd1},
		'{"3",   1'b0, 1'b0, KIND_NUMBER,    16'd0,  16'd0},
		'{".",   1'b1, 1'b0, KIND_NUMBER,    16'd0,  16'd0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	expression_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// scanner copy kept by the bench
	scan_t       sc_mode = SC_IDLE;
	logic [15:0] tok_start = '0;
	logic [15:0] tok_len = '0;
	logic        first_i = 1'b0;
	logic [15:0] next_pos = '0;

	token_t tokens_due[$];
	token_t step_tokens[$];
	int     errors = 0;
	bit     idle_on = 1'b1;
	bit     hold_req = 1'b0;
	bit     hold_done = 1'b0;
	string  op_chars = "+-*/%=";
	string  punct_chars = "()[],;";

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [15:0] capped(logic [15:0] a, int unsigned b);
		int unsigned s;
		s = int'(a) + b;
		if (s > int'(POS_CAP))
			s = POS_CAP;
		return s[15:0];
	endfunction

	function automatic void emit(kind_t kind, logic [15:0] start, logic [15:0] len);
		step_tokens.insert(step_tokens.size(), token_t'{kind, start, len, 1'b0});
	endfunction

	function automatic void close_pending();
		if (sc_mode == SC_INT || sc_mode == SC_DOT || sc_mode == SC_FRAC)
			emit(KIND_NUMBER, tok_start, tok_len);
		else if (sc_mode == SC_IDENT)
			emit((tok_len == 16'd1 && first_i) ? KIND_IMAGINARY : KIND_VARIABLE,
				tok_start, tok_len);
		sc_mode = SC_IDLE;
	endfunction

	function automatic void open_token(logic [7:0] ch, logic [15:0] pos);
		if (ch >= "0" && ch <= "9") begin
			sc_mode = SC_INT;
			tok_start = pos;
			tok_len = 16'd1;
		end else if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) begin
			sc_mode = SC_IDENT;
			tok_start = pos;
			tok_len = 16'd1;
			first_i = (ch == "i");
		end else begin
			case (ch)
				"+", "-", "*", "/", "%", "=": emit(KIND_OPERATOR, pos, 16'd1);
				"(": emit(KIND_LPAREN, pos, 16'd1);
				")": emit(KIND_RPAREN, pos, 16'd1);
				"[": emit(KIND_LBRACKET, pos, 16'd1);
				"]": emit(KIND_RBRACKET, pos, 16'd1);
				",": emit(KIND_COMMA, pos, 16'd1);
				";": emit(KIND_SEMICOLON, pos, 16'd1);
				default: ;
			endcase
		end
	endfunction

	// tokens caused by one byte land in step_tokens
	function automatic void scan_byte(logic [7:0] ch, logic eot);
		logic [15:0] pos;
		logic        digit;
		logic        word;
		pos = next_pos;
		digit = (ch >= "0" && ch <= "9");
		word = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_" || digit;
		step_tokens.delete();
		case (sc_mode)
			SC_INT: begin
				if (digit) begin
					tok_len = capped(tok_len, 1);
				end else if (ch == ".") begin
					sc_mode = SC_DOT;
				end else begin
					close_pending();
					open_token(ch, pos);
				end
			end
			SC_DOT: begin
				// dot only counts once a fraction digit shows up
				if (digit) begin
					tok_len = capped(tok_len, 2);
					sc_mode = SC_FRAC;
				end else begin
					close_pending();
					open_token(ch, pos);
				end
			end
			SC_FRAC: begin
				if (digit) begin
					tok_len = capped(tok_len, 1);
				end else begin
					close_pending();
					open_token(ch, pos);
				end
			end
			SC_IDENT: begin
				if (word) begin
					tok_len = capped(tok_len, 1);
				end else begin
					close_pending();
					open_token(ch, pos);
				end
			end
			default: open_token(ch, pos);
		endcase
		if (eot) begin
			close_pending();
			emit(KIND_END, capped(pos, 1), 16'd0);
			next_pos = '0;
		end else begin
			next_pos = capped(pos, 1);
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
	endfunction

	task automatic send_byte(logic [7:0] ch, logic eot, logic typed, token_t want);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 7);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= eot;
		do @(posedge clk); while (!s_tready);
		scan_byte(ch, eot);
		if (typed)
			tokens_due.insert(tokens_due.size(), want);
		else
			foreach (step_tokens[k])
				tokens_due.insert(tokens_due.size(), step_tokens[k]);
	endtask

	// token sink: checks each transfer, stalls in bursts and once for a long stretch
	initial begin
		token_t want;
		int     stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (tokens_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected token: kind %0d start %0d len %0d last %0b",
						$time, m_tdata[3:0], m_tdata[19:4], m_tdata[35:20], m_tlast);
				end else begin
					want = tokens_due.pop_front();
					if (m_tdata[3:0] !== want.kind || m_tdata[19:4] !== want.start ||
							m_tdata[35:20] !== want.len || m_tlast !== want.last) begin
						errors++;
						$display("%0t: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
							$time, want.kind, want.start, want.len, want.last,
							m_tdata[3:0], m_tdata[19:4], m_tdata[35:20], m_tlast);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				stall_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 6);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("%0t: no transfer for %0d cycles", $time, quiet);
					$display("end of test: mismatches");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [7:0] text_bytes[$];
		int         sent;
		int         pieces;
		int         n;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i].ch, DIRECTED[i].eot, DIRECTED[i].typed,
				'{DIRECTED[i].kind, DIRECTED[i].start, DIRECTED[i].len, 1'b1});

		// mostly well-formed expressions, with noise bytes mixed in
		hold_req = 1'b1;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			text_bytes.delete();
			pieces = $urandom_range(1, 8);
			repeat (pieces) begin
				case ($urandom_range(0, 11))
					0, 1: begin
						n = $urandom_range(1, 4);
						repeat (n)
							text_bytes.insert(text_bytes.size(),
								8'($urandom_range(48, 57)));
						if ($urandom_range(0, 1)) begin
							text_bytes.insert(text_bytes.size(), ".");
							n = $urandom_range(0, 3);
							repeat (n)
								text_bytes.insert(text_bytes.size(),
									8'($urandom_range(48, 57)));
						end
					end
					2, 3: begin
						text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, 1) ?
							$urandom_range(65, 90) : $urandom_range(97, 122)));
						n = $urandom_range(0, 4);
						repeat (n) begin
							case ($urandom_range(0, 2))
								0: text_bytes.insert(text_bytes.size(),
									8'($urandom_range(97, 122)));
								1: text_bytes.insert(text_bytes.size(),
									8'($urandom_range(48, 57)));
								default: text_bytes.insert(text_bytes.size(), "_");
							endcase
						end
					end
					4: text_bytes.insert(text_bytes.size(), "i");
					5, 6: text_bytes.insert(text_bytes.size(),
						op_chars[$urandom_range(0, 5)]);
					7: text_bytes.insert(text_bytes.size(),
						punct_chars[$urandom_range(0, 5)]);
					8: text_bytes.insert(text_bytes.size(), " ");
					9: text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, 255)));
					10: text_bytes.insert(text_bytes.size(), ".");
					default: text_bytes.insert(text_bytes.size(), "_");
				endcase
			end
			foreach (text_bytes[k]) begin
				if (sent >= CALM_FROM)
					idle_on = 1'b0;
				send_byte(text_bytes[k], k == text_bytes.size() - 1, 1'b0, '0);
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		wait (tokens_due.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
